### hw/rtl/dscpm_pkg.sv
`default_nettype none

package dscpm_pkg;

   // Defaults for the top-level parameters
   localparam int SLOTS_DEF        = 8;
   localparam int PAYLOAD_BITS_DEF = 64;

   // Fixed field widths of the request and response
   localparam int CNT_W        = 8;
   localparam int PAYLOAD_W    = 64;
   localparam int SLOT_FIELD_W = 3;

   // Counters pair modulo this value
   localparam int PAIR_MOD = 129;

   // Register port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAIR_OFFSET = 2'd1;

   // Amplifier codes
   localparam logic AMP_FIRST  = 1'b0;
   localparam logic AMP_SECOND = 1'b1;

   typedef struct packed {
      logic                 source_amp;
      logic [CNT_W-1:0]     packet_counter;
      logic [PAYLOAD_W-1:0] payload;
   } req_type;

   typedef struct packed {
      logic [SLOT_FIELD_W-1:0] first_slot;
      logic [SLOT_FIELD_W-1:0] second_slot;
      logic [CNT_W-1:0]        first_counter;
      logic [CNT_W-1:0]        second_counter;
      logic [PAYLOAD_W-1:0]    first_payload;
      logic [PAYLOAD_W-1:0]    second_payload;
      logic                    last;
   } rsp_type;

   // Verdict of the pair compare unit for the current slot pair
   typedef struct packed {
      logic first_skip;
      logic pair_hit;
   } cmp_res_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PRIME,
      ST_SCAN,
      ST_DONE
   } scan_state_type;

endpackage

`default_nettype wire

### hw/rtl/dscpm_ram.sv
`default_nettype none

module dscpm_ram #(
   parameter int WIDTH = 72,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one word, read one word with registered data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hw/rtl/dscpm_pair_cmp.sv
`default_nettype none

module dscpm_pair_cmp (
   input  wire logic                          first_valid,
   input  wire logic                          second_valid,
   input  wire logic [dscpm_pkg::CNT_W-1:0]   first_counter,
   input  wire logic [dscpm_pkg::CNT_W-1:0]   second_counter,
   input  wire logic [dscpm_pkg::CNT_W-1:0]   pair_offset,
   input  wire logic                          emitted_valid,
   input  wire logic [dscpm_pkg::CNT_W-1:0]   emitted_counter,
   output      dscpm_pkg::cmp_res_type        res
);

   import dscpm_pkg::*;

   localparam int DIFF_W = CNT_W + 2;

   logic [DIFF_W-1:0] diff;
   logic [DIFF_W-1:0] off;
   logic              offset_ok;
   logic              diff_hit;
   logic              repeat_first;

   // Keep the difference positive: first + 2*129 - second lies in 3..513
   assign diff = DIFF_W'(first_counter) + DIFF_W'(2 * PAIR_MOD) - DIFF_W'(second_counter);
   assign off  = DIFF_W'(pair_offset);

   // An offset outside the residue range never pairs
   assign offset_ok = (pair_offset < CNT_W'(PAIR_MOD));

   // Residue matches when diff equals offset plus a multiple of the modulus
   assign diff_hit = offset_ok &&
                     (diff == off ||
                      diff == off + DIFF_W'(PAIR_MOD) ||
                      diff == off + DIFF_W'(2 * PAIR_MOD) ||
                      diff == off + DIFF_W'(3 * PAIR_MOD));

   // Skip a first slot that is empty or repeats the last emitted counter
   assign repeat_first   = emitted_valid && (first_counter == emitted_counter);
   assign res.first_skip = !first_valid || repeat_first;
   assign res.pair_hit   = !res.first_skip && second_valid && diff_hit;

endmodule

`default_nettype wire

### hw/rtl/dual_stream_counter_pair_matcher.sv
// Channel   Ports                              Handshake
// --------  ---------------------------------  ----------------------------------
// request   start, busy, req_data              taken when start && !busy
// response  rsp_valid, rsp_data                one-cycle strobe, cannot be held off
// register  csr_valid, csr_ready, csr_index,   written when csr_valid && csr_ready
//           csr_wdata
//
// A stored request holds busy through the prime step, the scan and the closing step. The
// scan visits each first-ring slot in turn, passes over an empty or skipped one, and for
// each other one tries second-ring slots in order until a hit or the last slot.
// A request taken while disabled stores nothing. A response leaves in the cycle after the
// next hit; the final one leaves in the first idle clock, after busy has dropped.
// Reset is synchronous and empties both rings. The receiver cannot stall.
`default_nettype none

module dual_stream_counter_pair_matcher #(
   parameter int SLOTS        = dscpm_pkg::SLOTS_DEF,
   parameter int PAYLOAD_BITS = dscpm_pkg::PAYLOAD_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,

   input  wire logic                               start,
   output      logic                               busy,
   input  wire dscpm_pkg::req_type                 req_data,

   output      logic                               rsp_valid,
   output      dscpm_pkg::rsp_type                 rsp_data,

   input  wire logic                               csr_valid,
   output      logic                               csr_ready,
   input  wire logic [dscpm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [dscpm_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   import dscpm_pkg::*;

   localparam int               SLOT_W    = $clog2(SLOTS);
   localparam int               WORD_W    = CNT_W + PAYLOAD_BITS;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

   // Registers
   logic                 enable_ff;
   logic [CNT_W-1:0]     pair_offset_ff;

   scan_state_type       state_ff, state_in;
   logic [SLOTS-1:0]     first_valid_ff, first_valid_in;
   logic [SLOTS-1:0]     second_valid_ff, second_valid_in;
   logic [SLOT_W-1:0]    first_wptr_ff, first_wptr_in;
   logic [SLOT_W-1:0]    second_wptr_ff, second_wptr_in;
   logic [SLOT_W-1:0]    i_ff, i_in;
   logic [SLOT_W-1:0]    k_ff, k_in;
   logic                 emitted_valid_ff, emitted_valid_in;
   logic [CNT_W-1:0]     emitted_counter_ff, emitted_counter_in;
   logic                 pend_valid_ff, pend_valid_in;
   rsp_type              pend_ff, pend_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   // Combinational
   logic                 accept;
   logic                 store;
   logic                 first_we;
   logic                 second_we;
   logic [WORD_W-1:0]    wr_word;
   logic [WORD_W-1:0]    first_rd_word;
   logic [WORD_W-1:0]    second_rd_word;
   logic [CNT_W-1:0]     c1;
   logic [CNT_W-1:0]     c2;
   logic [PAYLOAD_BITS-1:0] p1;
   logic [PAYLOAD_BITS-1:0] p2;
   cmp_res_type          cmp_res;
   rsp_type              new_rsp;
   logic                 advance_i;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign store     = accept && enable_ff;
   assign csr_ready = !busy;

   // Ring write on a stored request
   assign first_we  = store && (req_data.source_amp == AMP_FIRST);
   assign second_we = store && (req_data.source_amp == AMP_SECOND);
   assign wr_word   = {req_data.packet_counter, req_data.payload[PAYLOAD_BITS-1:0]};

   dscpm_ram #(
      .WIDTH (WORD_W),
      .DEPTH (SLOTS)
   ) u_first_ring (
      .clock   (clock),
      .wr_en   (first_we),
      .wr_addr (first_wptr_ff),
      .wr_data (wr_word),
      .rd_addr (i_in),
      .rd_data (first_rd_word)
   );

   dscpm_ram #(
      .WIDTH (WORD_W),
      .DEPTH (SLOTS)
   ) u_second_ring (
      .clock   (clock),
      .wr_en   (second_we),
      .wr_addr (second_wptr_ff),
      .wr_data (wr_word),
      .rd_addr (k_in),
      .rd_data (second_rd_word)
   );

   assign c1 = first_rd_word[WORD_W-1 -: CNT_W];
   assign c2 = second_rd_word[WORD_W-1 -: CNT_W];
   assign p1 = first_rd_word[PAYLOAD_BITS-1:0];
   assign p2 = second_rd_word[PAYLOAD_BITS-1:0];

   // Shared compare unit, one slot pair per clock
   dscpm_pair_cmp u_pair_cmp (
      .first_valid     (first_valid_ff[i_ff]),
      .second_valid    (second_valid_ff[k_ff]),
      .first_counter   (c1),
      .second_counter  (c2),
      .pair_offset     (pair_offset_ff),
      .emitted_valid   (emitted_valid_ff),
      .emitted_counter (emitted_counter_ff),
      .res             (cmp_res)
   );

   // Build the response for the current slot pair
   always_comb begin
      new_rsp.first_slot     = SLOT_FIELD_W'(i_ff);
      new_rsp.second_slot    = SLOT_FIELD_W'(k_ff);
      new_rsp.first_counter  = c1;
      new_rsp.second_counter = c2;
      new_rsp.first_payload  = PAYLOAD_W'(p1);
      new_rsp.second_payload = PAYLOAD_W'(p2);
      new_rsp.last           = 1'b0;
   end

   // Sequencer: next state, scan indexes, ring bookkeeping, response queue
   always_comb begin
      state_in           = state_ff;
      first_valid_in     = first_valid_ff;
      second_valid_in    = second_valid_ff;
      first_wptr_in      = first_wptr_ff;
      second_wptr_in     = second_wptr_ff;
      i_in               = i_ff;
      k_in               = k_ff;
      emitted_valid_in   = emitted_valid_ff;
      emitted_counter_in = emitted_counter_ff;
      pend_valid_in      = pend_valid_ff;
      pend_in            = pend_ff;
      rsp_valid_in       = 1'b0;
      rsp_in             = rsp_ff;
      advance_i          = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            i_in = '0;
            k_in = '0;
            if (first_we) begin
               first_valid_in[first_wptr_ff] = 1'b1;
               first_wptr_in = (first_wptr_ff == LAST_SLOT) ? '0
                                                             : SLOT_W'(first_wptr_ff + 1'b1);
            end
            if (second_we) begin
               second_valid_in[second_wptr_ff] = 1'b1;
               second_wptr_in = (second_wptr_ff == LAST_SLOT) ? '0
                                                               : SLOT_W'(second_wptr_ff + 1'b1);
            end
            if (store) begin
               state_in = ST_PRIME;
            end
         end

         // Wait for the first read of slot pair zero
         ST_PRIME: begin
            state_in = ST_SCAN;
         end

         ST_SCAN: begin
            if (cmp_res.first_skip) begin
               advance_i = 1'b1;
            end else if (cmp_res.pair_hit) begin
               // Free both slots, send the held pair and hold this one
               first_valid_in[i_ff]  = 1'b0;
               second_valid_in[k_ff] = 1'b0;
               emitted_valid_in      = 1'b1;
               emitted_counter_in    = c1;
               if (pend_valid_ff) begin
                  rsp_in       = pend_ff;
                  rsp_valid_in = 1'b1;
               end
               pend_in       = new_rsp;
               pend_valid_in = 1'b1;
               advance_i     = 1'b1;
            end else if (k_ff == LAST_SLOT) begin
               advance_i = 1'b1;
            end else begin
               k_in = SLOT_W'(k_ff + 1'b1);
            end

            if (advance_i) begin
               k_in = '0;
               if (i_ff == LAST_SLOT) begin
                  state_in = ST_DONE;
               end else begin
                  i_in = SLOT_W'(i_ff + 1'b1);
               end
            end
         end

         // Send the held pair as the final one
         ST_DONE: begin
            if (pend_valid_ff) begin
               rsp_in        = pend_ff;
               rsp_in.last   = 1'b1;
               rsp_valid_in  = 1'b1;
               pend_valid_in = 1'b0;
            end
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_IDLE;
         first_valid_ff     <= '0;
         second_valid_ff    <= '0;
         first_wptr_ff      <= '0;
         second_wptr_ff     <= '0;
         i_ff               <= '0;
         k_ff               <= '0;
         emitted_valid_ff   <= 1'b0;
         emitted_counter_ff <= '0;
         pend_valid_ff      <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         state_ff           <= state_in;
         first_valid_ff     <= first_valid_in;
         second_valid_ff    <= second_valid_in;
         first_wptr_ff      <= first_wptr_in;
         second_wptr_ff     <= second_wptr_in;
         i_ff               <= i_in;
         k_ff               <= k_in;
         emitted_valid_ff   <= emitted_valid_in;
         emitted_counter_ff <= emitted_counter_in;
         pend_valid_ff      <= pend_valid_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff      <= 1'b0;
         pair_offset_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ENABLE:      enable_ff      <= csr_wdata[0];
            CSR_PAIR_OFFSET: pair_offset_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A matched pair frees both of its slots
   a_hit_frees_slots: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN && cmp_res.pair_hit |=>
         !first_valid_ff[$past(i_ff)] && !second_valid_ff[$past(k_ff)])
      else $error("matched slots not freed");

   // A held pair exists only while a scan is in progress or finishing
   a_pend_in_scan: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (state_ff == ST_SCAN || state_ff == ST_DONE))
      else $error("held pair outside a scan");

   // Responses leave only from the scan or its closing step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(state_ff) == ST_SCAN || $past(state_ff) == ST_DONE))
      else $error("response outside a scan");

   // The final marker comes only from the closing step
   a_last_at_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.last |-> $past(state_ff) == ST_DONE)
      else $error("final marker outside the closing step");

endmodule

`default_nettype wire
